>>> sv/suks_pkg.sv
package suks_pkg;

    // Table size and derived widths
    localparam int CAPACITY = 16;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths
    localparam int KEY_W    = 32;
    localparam int MODE_W   = 2;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;

    // Stream data widths, padded to whole bytes
    localparam int S_TDATA_W = ((KEY_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((KEY_W + COUNT_W + 7) / 8) * 8;

    // Request mode codes (high bit set means read by rank)
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_ABSENT    = 3'd3,
        ST_FULL      = 3'd4,
        ST_READ_OK   = 3'd5,
        ST_EMPTY_POS = 3'd6
    } status_t;

    // Key RAM access for one cycle
    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [KEY_W-1:0]  wdata;
        logic [ADDR_W-1:0]        raddr;
    } ram_req_t;

    // One finished result
    typedef struct packed {
        status_t                  status;
        logic signed [KEY_W-1:0]  key_out;
        logic [COUNT_W-1:0]       count;
    } result_t;

endpackage

>>> sv/sorted_unique_key_set.sv
// Sorted set of distinct signed 32-bit keys, up to 16 entries, kept in
// ascending order in a single-port-write key RAM.
// Request channel (s_*): tuser carries the mode (insert, delete, read by
// rank; mode 3 also reads), tdata carries the key and the rank.
// Result channel (m_*): one result per request, tuser carries the status,
// tdata the key read (zero unless a read hit) and the key count after it.
// A read goes from acceptance through a RAM read wait state and a finish
// state to the output register. Insert and delete walk the table one
// entry per cycle from rank 0 over the n keys held; the scan ends early
// when an insert finds its key or meets a larger key in a full table, or
// when a delete passes its key. One request is in progress at a time, and
// the next request is taken in the cycle after the result moves to the
// output register.
// A new request is taken while the previous result still waits on m_*;
// the next result is held back until the output register is free, so a
// stalled receiver holds everything else in place.
// Reset empties the table at once (count to zero); no clearing pass is run
// and RAM contents beyond the count are never used.
module sorted_unique_key_set (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [suks_pkg::S_TDATA_W-1:0]    s_tdata,   // key[31:0], position[35:32], pad
    input  logic [suks_pkg::MODE_W-1:0]       s_tuser,   // mode[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [suks_pkg::M_TDATA_W-1:0]    m_tdata,   // key_out[31:0], count[36:32], pad
    output logic [suks_pkg::STATUS_W-1:0]     m_tuser    // status[2:0]
);
    import suks_pkg::*;

    ram_req_t                ram_req;
    logic signed [KEY_W-1:0] ram_rdata;
    result_t                 res;
    logic                    res_valid;
    logic                    res_free;

    logic                    m_valid_reg, m_valid_next;
    result_t                 m_res_reg, m_res_next;

    suks_key_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    suks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .mode      (s_tuser),
        .key       (s_tdata[KEY_W-1:0]),
        .position  (s_tdata[KEY_W+POS_W-1:KEY_W]),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    // Output register: free when empty or being drained this cycle
    assign res_free = !m_valid_reg || m_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_valid)
        begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {{(M_TDATA_W - KEY_W - COUNT_W){1'b0}},
                       m_res_reg.count, m_res_reg.key_out};

endmodule

>>> sv/suks_key_ram.sv
module suks_key_ram (
    input  logic                                   clk,
    input  suks_pkg::ram_req_t                     req,
    output logic signed [suks_pkg::KEY_W-1:0]      rdata
);
    import suks_pkg::*;

    logic signed [KEY_W-1:0] mem [CAPACITY];
    logic signed [KEY_W-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/suks_ctrl.sv
module suks_ctrl (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [suks_pkg::MODE_W-1:0]            mode,
    input  logic signed [suks_pkg::KEY_W-1:0]      key,
    input  logic [suks_pkg::POS_W-1:0]             position,
    input  logic                                   res_free,
    output logic                                   res_valid,
    output suks_pkg::result_t                      res,
    output suks_pkg::ram_req_t                     ram_req,
    input  logic signed [suks_pkg::KEY_W-1:0]      ram_rdata
);
    import suks_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_RDWAIT = 4'b0100,
        S_FIN    = 4'b1000
    } state_t;

    typedef enum logic [1:0] {
        OP_INS,
        OP_DEL,
        OP_RD
    } op_t;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [CNT_W-1:0]        ix_reg, ix_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    flag_reg, flag_next;     // placed (insert) / found (delete)
    logic signed [KEY_W-1:0] carry_reg, carry_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    status_t                 status_reg, status_next;
    logic signed [KEY_W-1:0] key_out_reg, key_out_next;

    logic [CNT_W-1:0]        ix_inc;
    logic                    at_end;
    logic                    full;

    assign ix_inc = ix_reg + 1'b1;
    assign at_end = (ix_reg == count_reg);
    assign full   = (count_reg == CNT_W'(CAPACITY));

    // Sequencer: one table entry per cycle, read of entry i+1 overlaps the
    // write of entry i (insert) or i-1 (delete), so addresses never collide.
    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        ix_next       = ix_reg;
        count_next    = count_reg;
        flag_next     = flag_reg;
        carry_next    = carry_reg;
        key_next      = key_reg;
        pos_next      = pos_reg;
        status_next   = status_reg;
        key_out_next  = key_out_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = ADDR_W'(ix_reg);
        ram_req.wdata = key_reg;
        ram_req.raddr = ADDR_W'(ix_inc);
        res_valid     = 1'b0;
        in_ready      = (state_reg == S_IDLE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    key_next     = key;
                    pos_next     = position;
                    ix_next      = '0;
                    flag_next    = 1'b0;
                    key_out_next = '0;
                    if (mode[MODE_W-1])
                    begin
                        op_next       = OP_RD;
                        ram_req.raddr = ADDR_W'(position);
                        state_next    = S_RDWAIT;
                    end
                    else
                    begin
                        op_next       = (mode == MODE_DELETE) ? OP_DEL : OP_INS;
                        ram_req.raddr = '0;
                        state_next    = S_SCAN;
                    end
                end
            end

            S_RDWAIT:
            begin
                if (32'(pos_reg) < 32'(count_reg))
                begin
                    status_next  = ST_READ_OK;
                    key_out_next = ram_rdata;
                end
                else
                begin
                    status_next  = ST_EMPTY_POS;
                end
                state_next = S_FIN;
            end

            S_SCAN:
            begin
                if (op_reg == OP_INS)
                begin
                    if (flag_reg)
                    begin
                        // ripple the displaced key one slot up
                        ram_req.we    = 1'b1;
                        ram_req.wdata = carry_reg;
                        carry_next    = ram_rdata;
                        if (at_end)
                        begin
                            count_next  = count_reg + 1'b1;
                            status_next = ST_INSERTED;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            ix_next = ix_inc;
                        end
                    end
                    else if (at_end)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ram_req.we  = 1'b1;
                            count_next  = count_reg + 1'b1;
                            status_next = ST_INSERTED;
                        end
                        state_next = S_FIN;
                    end
                    else if (ram_rdata == key_reg)
                    begin
                        status_next = ST_PRESENT;
                        state_next  = S_FIN;
                    end
                    else if (ram_rdata > key_reg)
                    begin
                        if (full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            // insertion point: new key here, old one carried
                            ram_req.we = 1'b1;
                            carry_next = ram_rdata;
                            flag_next  = 1'b1;
                            ix_next    = ix_inc;
                        end
                    end
                    else
                    begin
                        ix_next = ix_inc;
                    end
                end
                else
                begin
                    if (flag_reg)
                    begin
                        if (at_end)
                        begin
                            count_next  = count_reg - 1'b1;
                            status_next = ST_REMOVED;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            // close the gap: move entry down one slot
                            ram_req.we    = 1'b1;
                            ram_req.waddr = ADDR_W'(ix_reg - 1'b1);
                            ram_req.wdata = ram_rdata;
                            ix_next       = ix_inc;
                        end
                    end
                    else if (at_end || (ram_rdata > key_reg))
                    begin
                        status_next = ST_ABSENT;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        if (ram_rdata == key_reg)
                        begin
                            flag_next = 1'b1;
                        end
                        ix_next = ix_inc;
                    end
                end
            end

            S_FIN:
            begin
                res_valid = res_free;
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.status  = status_reg;
    assign res.key_out = key_out_reg;
    assign res.count   = COUNT_W'(count_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            flag_reg  <= 1'b0;
            ix_reg    <= '0;
            op_reg    <= OP_INS;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
            ix_reg    <= ix_next;
            op_reg    <= op_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        carry_reg   <= carry_next;
        key_reg     <= key_next;
        pos_reg     <= pos_next;
        status_reg  <= status_next;
        key_out_reg <= key_out_next;
    end

    // Key count only moves at the end of a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == S_SCAN))
        else $error("key count changed outside a scan");

    // Table never exceeds its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    // RAM writes stay inside the live part of the table plus one slot;
    // a delete may shift entries in a full table
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> ((state_reg == S_SCAN) && (ix_reg <= count_reg) &&
                        ((op_reg == OP_DEL) || !full)))
        else $error("key RAM write out of range");

    // An accepted request always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

endmodule

>>> sim/tb_top.sv
module tb_top;

    import suks_pkg::*;

    // Read codes; the high mode bit selects a read by rank
    localparam logic [MODE_W-1:0] MODE_READ     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ_ALT = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    localparam int POOL_SIZE  = 20;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 152;
    localparam int DRAIN_WAIT = 40;

    // One pending request plus the idle cycles placed ahead of it
    typedef struct {
        logic [MODE_W-1:0]       mode;
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        pos;
        int                      gap;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    request_t pending_requests[$];
    result_t expected_results[$];

    // Shadow copy of the sorted table
    logic signed [KEY_W-1:0] table_keys [CAPACITY];
    int held = 0;

    int errors = 0;
    int gap_left = 0;
    int rx_stall = 0;
    int results_seen = 0;

    sorted_unique_key_set dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 clk = ~clk;

    // Apply one request to the shadow table and return its result
    function automatic result_t apply_request(logic [MODE_W-1:0] mode,
                                              logic signed [KEY_W-1:0] key,
                                              logic [POS_W-1:0] pos);
        result_t res;
        int rank;
        bit found;
        res.key_out = '0;
        if (mode[1])
        begin
            if (pos < held)
            begin
                res.status  = ST_READ_OK;
                res.key_out = table_keys[pos];
            end
            else
            begin
                res.status = ST_EMPTY_POS;
            end
        end
        else
        begin
            // first rank whose key is not below the request key (signed order)
            rank = 0;
            while (rank < held && table_keys[rank] < key)
                rank++;
            found = (rank < held) && (table_keys[rank] == key);
            if (mode == MODE_INSERT)
            begin
                if (found)
                    res.status = ST_PRESENT;
                else if (held >= CAPACITY)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = held; i > rank; i--)
                        table_keys[i] = table_keys[i-1];
                    table_keys[rank] = key;
                    held++;
                    res.status = ST_INSERTED;
                end
            end
            else
            begin
                if (found)
                begin
                    for (int i = rank; i < held - 1; i++)
                        table_keys[i] = table_keys[i+1];
                    held--;
                    table_keys[held] = '0;
                    res.status = ST_REMOVED;
                end
                else
                begin
                    res.status = ST_ABSENT;
                end
            end
        end
        res.count = held[COUNT_W-1:0];
        return res;
    endfunction

    // Request driver: predict on acceptance, then present the next request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_request(s_tuser, s_tdata[KEY_W-1:0],
                                                         s_tdata[KEY_W +: POS_W]));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    request_t req;
                    req = pending_requests.pop_front();
                    s_tdata  <= {{(S_TDATA_W-KEY_W-POS_W){1'b0}}, req.pos, req.key};
                    s_tuser  <= req.mode;
                    s_tvalid <= 1'b1;
                    gap_left = (pending_requests.size() != 0) ? pending_requests[0].gap : 0;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest prediction, stall at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result status %0d key %0d count %0d", $time,
                             m_tuser, $signed(m_tdata[KEY_W-1:0]), m_tdata[KEY_W +: COUNT_W]);
                    errors++;
                end
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    if (m_tuser !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time,
                                 want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[KEY_W-1:0] !== want.key_out)
                    begin
                        $display("%0t: key_out expected %0d, got %0d", $time,
                                 want.key_out, $signed(m_tdata[KEY_W-1:0]));
                        errors++;
                    end
                    if (m_tdata[KEY_W +: COUNT_W] !== want.count)
                    begin
                        $display("%0t: count expected %0d, got %0d", $time,
                                 want.count, m_tdata[KEY_W +: COUNT_W]);
                        errors++;
                    end
                end
                results_seen++;
                // calm stretch with no backpressure every so often
                rx_stall = (results_seen % 200 < 40) ? 0 : $urandom_range(0, 3);
            end
            else if (rx_stall > 0)
            begin
                rx_stall--;
            end
            m_tready <= (rx_stall == 0);
        end
    end

    task automatic add_request(logic [MODE_W-1:0] mode, logic signed [KEY_W-1:0] key,
                               logic [POS_W-1:0] pos, int gap);
        request_t req;
        req.mode = mode;
        req.key  = key;
        req.pos  = pos;
        req.gap  = gap;
        pending_requests.push_back(req);
    endtask

    // Stimulus, reset and end of run
    initial
    begin
        logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [MODE_W-1:0] mode;
        logic signed [KEY_W-1:0] key;
        int pick;
        int ins_cut;
        int del_cut;
        bit calm;

        // directed: empty table, signed order, duplicates, full table
        add_request(MODE_READ, 32'sd0, 4'd0, 0);
        add_request(MODE_DELETE, 32'sd5, 4'd0, $urandom_range(0, 3));
        add_request(MODE_INSERT, KEY_MAX, 4'd15, 0);
        add_request(MODE_INSERT, KEY_MIN, 4'd0, 0);
        add_request(MODE_INSERT, 32'sd0, 4'd0, 1);
        add_request(MODE_INSERT, -32'sd1, 4'd0, 0);
        add_request(MODE_INSERT, KEY_MAX, 4'd0, 0);
        add_request(MODE_READ_ALT, -32'sd1, 4'd0, 2);
        add_request(MODE_READ, 32'sd0, 4'd15, 0);
        add_request(MODE_DELETE, KEY_MIN, 4'd0, 0);
        for (int i = 0; i < 13; i++)
            add_request(MODE_INSERT, 32'sd100 + i, 4'd0, $urandom_range(0, 3));
        add_request(MODE_INSERT, 32'sd7, 4'd0, 0);
        add_request(MODE_INSERT, 32'sd0, 4'd0, 0);
        add_request(MODE_READ, 32'sd0, 4'd15, 3);
        add_request(MODE_DELETE, KEY_MAX, 4'd0, 0);

        // random phases: a small key pool so the table fills, hits and drains
        for (int ph = 0; ph < PHASES; ph++)
        begin
            for (int i = 0; i < POOL_SIZE; i++)
                key_pool[i] = $urandom;
            if (ph % 2 == 0)
            begin
                key_pool[0] = KEY_MIN;
                key_pool[1] = KEY_MAX;
                key_pool[2] = -32'sd1;
                key_pool[3] = 32'sd0;
            end
            case (ph % 3)
                0: begin ins_cut = 60; del_cut = 75; end
                1: begin ins_cut = 25; del_cut = 75; end
                default: begin ins_cut = 40; del_cut = 70; end
            endcase
            calm = (ph % 4 == 3);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < ins_cut)
                    mode = MODE_INSERT;
                else if (pick < del_cut)
                    mode = MODE_DELETE;
                else
                    mode = $urandom_range(0, 1) ? MODE_READ_ALT : MODE_READ;
                key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                                  : $urandom;
                add_request(mode, key, POS_W'($urandom_range(0, 15)),
                            calm ? 0 : $urandom_range(0, 3));
            end
        end

        gap_left = pending_requests[0].gap;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // wait until every request is in and every result is back
        @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("sorted_unique_key_set regression: pass");
        else
            $display("sorted_unique_key_set regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("sorted_unique_key_set regression: fail");
        $finish;
    end

endmodule

>>> files.f
sv/suks_pkg.sv
sv/suks_key_ram.sv
sv/suks_ctrl.sv
sv/sorted_unique_key_set.sv
sim/tb_top.sv
